[sv/asp_pkg.sv]
// ----------------------------------------------------------------------------
// asp_pkg: shared types and constants of the aligned shard placer
// widths, status codes, register indexes and the step unit result bundle
// ----------------------------------------------------------------------------
`default_nettype none

package asp_pkg;

  // field widths
  localparam int BYTES_W = 32;
  localparam int ALIGN_W = 32;
  localparam int TAG_W   = 16;
  localparam int BUF_W   = 16;
  localparam int CAP_W   = 33;
  localparam int STAT_W  = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 33;

  // capacity limits and reset values
  localparam logic [CAP_W-1:0]   CAP_MIN          = 33'd134217728;
  localparam logic [CAP_W-1:0]   CAP_MAX          = 33'd4294967296;
  localparam logic [CAP_W-1:0]   CAP_RESET        = 33'd268435456;
  localparam logic [ALIGN_W-1:0] BASE_ALIGN_RESET = 32'd256;

  localparam int BUFFER_COUNT_LIMIT_DEF = 65536;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ALIGNMENT  = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK             = 3'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_SIZE      = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_ITEM_ALIGN = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_BASE_ALIGN = 3'd3;
  localparam logic [STAT_W-1:0] ST_INDEX_OVERFLOW = 3'd4;
  localparam logic [STAT_W-1:0] ST_FAILED_EARLIER = 3'd5;

  // outputs of the shared align / slice unit
  typedef struct packed {
    logic [CAP_W:0]     aligned;     // rounded-up fill, one spare bit
    logic               at_cap;      // registered aligned fill reached capacity
    logic               take_all;    // rest of the request fits in the room
    logic [BYTES_W-1:0] len;         // slice length
    logic [CAP_W-1:0]   fill_after;  // fill after the slice
    logic [BYTES_W-1:0] rem_after;   // bytes still to place after the slice
  } asp_step_t;

endpackage

`default_nettype wire

[sv/asp_slice_unit.sv]
// ----------------------------------------------------------------------------
// asp_slice_unit: shared align and slice arithmetic
// rounds the fill up to the alignment and cuts one slice from the aligned fill
// ----------------------------------------------------------------------------
`default_nettype none

module asp_slice_unit (
  input  wire logic [asp_pkg::CAP_W-1:0]   fill,
  input  wire logic [asp_pkg::ALIGN_W-1:0] mask,
  input  wire logic [asp_pkg::CAP_W:0]     aligned_in,
  input  wire logic [asp_pkg::CAP_W-1:0]   capacity,
  input  wire logic [asp_pkg::BYTES_W-1:0] remaining,
  output asp_pkg::asp_step_t               step
);

  logic [asp_pkg::CAP_W:0]   mask_ext;
  logic [asp_pkg::CAP_W-1:0] room;
  logic [asp_pkg::CAP_W-1:0] rem_ext;

  assign mask_ext = {2'b00, mask};
  assign rem_ext  = {1'b0, remaining};

  // round up: (fill + mask) & ~mask
  assign step.aligned = ({1'b0, fill} + mask_ext) & ~mask_ext;

  assign step.at_cap = (aligned_in >= {1'b0, capacity});

  // room is only meaningful below capacity
  assign room          = capacity - aligned_in[asp_pkg::CAP_W-1:0];
  assign step.take_all = (rem_ext <= room);

  assign step.len = step.take_all ? remaining : room[asp_pkg::BYTES_W-1:0];
  assign step.fill_after = step.take_all ? (aligned_in[asp_pkg::CAP_W-1:0] + rem_ext)
                                         : capacity;
  assign step.rem_after = step.take_all ? '0
                                        : (remaining - room[asp_pkg::BYTES_W-1:0]);

endmodule

`default_nettype wire

[sv/aligned_shard_placer.sv]
// ----------------------------------------------------------------------------
// aligned_shard_placer: greedy placer of buffer requests into device buffers
// packs requests into fixed-capacity buffers, splitting them into slices
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): one transaction per request. the block
//   raises in_stall while it works on a request and takes the next one when
//   the sequencer is back in idle.
//   result channel (out_valid / out_stall): one transaction per slice, the
//   last one of a request flagged by out_last_slice. an error gives exactly one
//   result with a nonzero status.
//   config channel (cfg_valid / cfg_ready): index 0 is buffer capacity
//   (clamped to 2^27..2^32), index 1 is the base alignment. write only
//   while the block is idle.
// sequence
//   accept in idle, then per slice an align step and a cut step through the
//   shared align / slice unit; a buffer switch adds a step in the cut state.
//   a request error is reported from the align step, an index overflow from
//   the cut step, and every result is registered in the output register.
// stalls
//   results leave through one output register. a stalled result holds, and
//   the sequencer waits at the next slice until the register frees up.
// reset
//   synchronous active-low rst_n restores default capacity and alignment,
//   buffer index and fill zero, no failure, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module aligned_shard_placer #(
  parameter int BUFFER_COUNT_LIMIT = asp_pkg::BUFFER_COUNT_LIMIT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // request channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [asp_pkg::BYTES_W-1:0]      in_request_bytes,
  input  wire logic [asp_pkg::ALIGN_W-1:0]      in_request_alignment,
  input  wire logic [asp_pkg::TAG_W-1:0]        in_item_tag,
  input  wire logic                             in_new_plan,
  // slice channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [asp_pkg::STAT_W-1:0]            out_status,
  output logic [asp_pkg::TAG_W-1:0]             out_tag_out,
  output logic [asp_pkg::BUF_W-1:0]             out_buffer_number,
  output logic [asp_pkg::BYTES_W-1:0]           out_device_offset,
  output logic [asp_pkg::BYTES_W-1:0]           out_request_offset,
  output logic [asp_pkg::BYTES_W-1:0]           out_slice_bytes,
  output logic [asp_pkg::CAP_W-1:0]             out_fill_after,
  output logic                                  out_last_slice,
  // configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [asp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [asp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // overflow bound on the next buffer index, one bit wider than the index
  localparam logic [asp_pkg::BUF_W:0] LIMIT_W = (asp_pkg::BUF_W+1)'(BUFFER_COUNT_LIMIT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALIGN,
    S_SLICE
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [asp_pkg::CAP_W-1:0]   cap_r, cap_nxt;
  logic [asp_pkg::ALIGN_W-1:0] base_r, base_nxt;

  // plan state
  logic [asp_pkg::BUF_W-1:0]   buf_r, buf_nxt;
  logic [asp_pkg::CAP_W-1:0]   fill_r, fill_nxt;
  logic                        failed_r, failed_nxt;

  // current request
  logic [asp_pkg::STAT_W-1:0]  code_r, code_nxt;
  logic [asp_pkg::ALIGN_W-1:0] mask_r, mask_nxt;
  logic [asp_pkg::TAG_W-1:0]   tag_r, tag_nxt;
  logic [asp_pkg::BYTES_W-1:0] rem_r, rem_nxt;
  logic [asp_pkg::BYTES_W-1:0] logical_r, logical_nxt;
  logic [asp_pkg::CAP_W:0]     aligned_r, aligned_nxt;

  // output register
  logic                        ovalid_r, ovalid_nxt;
  logic [asp_pkg::STAT_W-1:0]  ostat_r, ostat_nxt;
  logic [asp_pkg::TAG_W-1:0]   otag_r, otag_nxt;
  logic [asp_pkg::BUF_W-1:0]   obuf_r, obuf_nxt;
  logic [asp_pkg::BYTES_W-1:0] odev_r, odev_nxt;
  logic [asp_pkg::BYTES_W-1:0] olog_r, olog_nxt;
  logic [asp_pkg::BYTES_W-1:0] olen_r, olen_nxt;
  logic [asp_pkg::CAP_W-1:0]   ofill_r, ofill_nxt;
  logic                        olast_r, olast_nxt;

  asp_pkg::asp_step_t step;

  logic                        in_take;
  logic                        out_free;
  logic                        base_pow2;
  logic                        item_pow2;
  logic                        failed_eff;
  logic [asp_pkg::ALIGN_W-1:0] eff_align;
  logic [asp_pkg::BUF_W:0]     next_idx;
  logic                        idx_overflow;

  // shared align / slice unit
  asp_slice_unit u_slice (
    .fill       (fill_r),
    .mask       (mask_r),
    .aligned_in (aligned_r),
    .capacity   (cap_r),
    .remaining  (rem_r),
    .step       (step)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  // output register empty, or its transaction completes this cycle
  assign out_free  = !ovalid_r || !out_stall;

  // checks done at accept time, after a possible new plan
  assign base_pow2  = (base_r != '0) && ((base_r & (base_r - 1'b1)) == '0);
  assign item_pow2  = (in_request_alignment != '0)
                      && ((in_request_alignment & (in_request_alignment - 1'b1)) == '0);
  assign failed_eff = failed_r && !in_new_plan;
  assign eff_align  = (base_r > in_request_alignment) ? base_r : in_request_alignment;

  assign next_idx     = {1'b0, buf_r} + {{asp_pkg::BUF_W{1'b0}}, 1'b1};
  assign idx_overflow = (next_idx >= LIMIT_W);

  always_comb begin
    state_nxt   = state_r;
    cap_nxt     = cap_r;
    base_nxt    = base_r;
    buf_nxt     = buf_r;
    fill_nxt    = fill_r;
    failed_nxt  = failed_r;
    code_nxt    = code_r;
    mask_nxt    = mask_r;
    tag_nxt     = tag_r;
    rem_nxt     = rem_r;
    logical_nxt = logical_r;
    aligned_nxt = aligned_r;

    // a completed result transaction empties the register
    ovalid_nxt = ovalid_r && out_stall;
    ostat_nxt  = ostat_r;
    otag_nxt   = otag_r;
    obuf_nxt   = obuf_r;
    odev_nxt   = odev_r;
    olog_nxt   = olog_r;
    olen_nxt   = olen_r;
    ofill_nxt  = ofill_r;
    olast_nxt  = olast_r;

    // register writes, capacity clamped into its legal range
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        asp_pkg::REG_BUFFER_CAPACITY: begin
          priority if (cfg_data < asp_pkg::CAP_MIN) cap_nxt = asp_pkg::CAP_MIN;
          else if (cfg_data > asp_pkg::CAP_MAX)     cap_nxt = asp_pkg::CAP_MAX;
          else                                      cap_nxt = cfg_data;
        end
        asp_pkg::REG_BASE_ALIGNMENT: begin
          base_nxt = cfg_data[asp_pkg::ALIGN_W-1:0];
        end
        default: begin
        end
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_new_plan) begin
            buf_nxt  = '0;
            fill_nxt = '0;
          end
          failed_nxt  = failed_eff;
          tag_nxt     = in_item_tag;
          rem_nxt     = in_request_bytes;
          logical_nxt = '0;
          mask_nxt    = eff_align - 1'b1;
          priority if (failed_eff)           code_nxt = asp_pkg::ST_FAILED_EARLIER;
          else if (!base_pow2)               code_nxt = asp_pkg::ST_BAD_BASE_ALIGN;
          else if (in_request_bytes == '0)   code_nxt = asp_pkg::ST_ZERO_SIZE;
          else if (!item_pow2)               code_nxt = asp_pkg::ST_BAD_ITEM_ALIGN;
          else                               code_nxt = asp_pkg::ST_OK;
          state_nxt = S_ALIGN;
        end
      end

      S_ALIGN: begin
        if (code_r != asp_pkg::ST_OK) begin
          // single error result, plan fails
          if (out_free) begin
            ovalid_nxt = 1'b1;
            ostat_nxt  = code_r;
            otag_nxt   = tag_r;
            obuf_nxt   = buf_r;
            odev_nxt   = '0;
            olog_nxt   = '0;
            olen_nxt   = '0;
            ofill_nxt  = '0;
            olast_nxt  = 1'b1;
            failed_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          aligned_nxt = step.aligned;
          state_nxt   = S_SLICE;
        end
      end

      S_SLICE: begin
        if (step.at_cap) begin
          if (idx_overflow) begin
            // slices already sent stand, index and fill stay
            if (out_free) begin
              ovalid_nxt = 1'b1;
              ostat_nxt  = asp_pkg::ST_INDEX_OVERFLOW;
              otag_nxt   = tag_r;
              obuf_nxt   = buf_r;
              odev_nxt   = '0;
              olog_nxt   = '0;
              olen_nxt   = '0;
              ofill_nxt  = '0;
              olast_nxt  = 1'b1;
              failed_nxt = 1'b1;
              state_nxt  = S_IDLE;
            end
          end else begin
            // fresh buffer: its aligned fill is zero, the cut follows in the slice state
            buf_nxt     = next_idx[asp_pkg::BUF_W-1:0];
            fill_nxt    = '0;
            aligned_nxt = '0;
          end
        end else if (out_free) begin
          ovalid_nxt  = 1'b1;
          ostat_nxt   = asp_pkg::ST_OK;
          otag_nxt    = tag_r;
          obuf_nxt    = buf_r;
          odev_nxt    = aligned_r[asp_pkg::BYTES_W-1:0];
          olog_nxt    = logical_r;
          olen_nxt    = step.len;
          ofill_nxt   = step.fill_after;
          olast_nxt   = step.take_all;
          fill_nxt    = step.fill_after;
          rem_nxt     = step.rem_after;
          logical_nxt = logical_r + step.len;
          state_nxt   = step.take_all ? S_IDLE : S_ALIGN;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    // payload, no reset needed
    code_r    <= code_nxt;
    mask_r    <= mask_nxt;
    tag_r     <= tag_nxt;
    rem_r     <= rem_nxt;
    logical_r <= logical_nxt;
    aligned_r <= aligned_nxt;
    ostat_r   <= ostat_nxt;
    otag_r    <= otag_nxt;
    obuf_r    <= obuf_nxt;
    odev_r    <= odev_nxt;
    olog_r    <= olog_nxt;
    olen_r    <= olen_nxt;
    ofill_r   <= ofill_nxt;
    olast_r   <= olast_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cap_r    <= asp_pkg::CAP_RESET;
      base_r   <= asp_pkg::BASE_ALIGN_RESET;
      buf_r    <= '0;
      fill_r   <= '0;
      failed_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cap_r    <= cap_nxt;
      base_r   <= base_nxt;
      buf_r    <= buf_nxt;
      fill_r   <= fill_nxt;
      failed_r <= failed_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid          = ovalid_r;
  assign out_status         = ostat_r;
  assign out_tag_out        = otag_r;
  assign out_buffer_number  = obuf_r;
  assign out_device_offset  = odev_r;
  assign out_request_offset = olog_r;
  assign out_slice_bytes    = olen_r;
  assign out_fill_after     = ofill_r;
  assign out_last_slice     = olast_r;

  // an accepted request keeps the input side closed for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_stall)
    else $error("request channel open right after an accept");

  // an ok slice ends where its offset plus length says
  a_fill_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && (ostat_r == asp_pkg::ST_OK))
      |-> (ofill_r == ({1'b0, odev_r} + {1'b0, olen_r})))
    else $error("slice fill does not match offset plus length");

  // an ok slice stays inside its buffer
  a_fill_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && (ostat_r == asp_pkg::ST_OK)) |-> (ofill_r <= cap_r))
    else $error("slice runs past buffer capacity");

  // an error result is final and carries no bytes
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && (ostat_r != asp_pkg::ST_OK)) |-> (olast_r && (olen_r == '0)))
    else $error("error result not final or not empty");

  // any error result leaves the plan failed
  a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_nxt && !ovalid_r && (ostat_nxt != asp_pkg::ST_OK)) |=> failed_r)
    else $error("error did not mark the plan failed");

endmodule

`default_nettype wire

[sim/tb_aligned_shard_placer.sv]
// ----------------------------------------------------------------------------
// tb_aligned_shard_placer: self-checking bench of the aligned shard placer
// a directed table, a run into buffer index overflow and random phases of
// requests are driven through the request channel. every slice that leaves
// the block is compared field by field with a hand-written or predicted slice.
// ----------------------------------------------------------------------------
module tb_aligned_shard_placer;
  timeunit 1ns;
  timeprecision 1ps;

  // buffer limit of the instance, the block's default
  localparam int BUF_LIMIT     = asp_pkg::BUFFER_COUNT_LIMIT_DEF;
  // cycles left to settle after the last slice of a batch, and a stuck guard
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_GUARD   = 5000;

  // one request transaction
  typedef struct {
    logic [asp_pkg::BYTES_W-1:0] nbytes;
    logic [asp_pkg::ALIGN_W-1:0] ralign;
    logic [asp_pkg::TAG_W-1:0]   tag;
    logic                        np;
  } req_t;

  // one slice transaction
  typedef struct {
    logic [asp_pkg::STAT_W-1:0]  status;
    logic [asp_pkg::TAG_W-1:0]   tag;
    logic [asp_pkg::BUF_W-1:0]   buf_num;
    logic [asp_pkg::BYTES_W-1:0] dev_off;
    logic [asp_pkg::BYTES_W-1:0] log_off;
    logic [asp_pkg::BYTES_W-1:0] len;
    logic [asp_pkg::CAP_W-1:0]   fill;
    logic                        last;
  } slice_t;

  typedef enum bit {ROW_REQUEST, ROW_CONFIG} row_kind_t;

  // one line of the directed table; want is used only when typed is set
  typedef struct {
    row_kind_t                          kind;
    req_t                               req;
    logic [asp_pkg::CFG_IDX_W-1:0]      reg_idx;
    logic [asp_pkg::CFG_DATA_W-1:0]     reg_data;
    bit                                 typed;
    slice_t                             want;
  } row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [asp_pkg::BYTES_W-1:0]    in_request_bytes = '0;
  logic [asp_pkg::ALIGN_W-1:0]    in_request_alignment = '0;
  logic [asp_pkg::TAG_W-1:0]      in_item_tag = '0;
  logic                           in_new_plan = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [asp_pkg::STAT_W-1:0]     out_status;
  logic [asp_pkg::TAG_W-1:0]      out_tag_out;
  logic [asp_pkg::BUF_W-1:0]      out_buffer_number;
  logic [asp_pkg::BYTES_W-1:0]    out_device_offset;
  logic [asp_pkg::BYTES_W-1:0]    out_request_offset;
  logic [asp_pkg::BYTES_W-1:0]    out_slice_bytes;
  logic [asp_pkg::CAP_W-1:0]      out_fill_after;
  logic                           out_last_slice;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [asp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [asp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state: configuration and the plan being built
  logic [63:0] plan_capacity;
  logic [63:0] plan_base_align;
  logic [63:0] plan_fill;
  int          plan_buffer;
  bit          plan_failed;

  slice_t      new_slices[$];      // slices caused by the latest request
  slice_t      awaited_slices[$];  // slices predicted but not yet seen
  slice_t      head;
  row_t        script[$];
  int          fail_count = 0;
  bit          idle_on = 1'b1;     // random gaps and stalls enabled
  int          stall_left = 0;
  int unsigned stall_draw;

  always #5 clk = ~clk;

  aligned_shard_placer #(
    .BUFFER_COUNT_LIMIT(BUF_LIMIT)
  ) DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_request_bytes     (in_request_bytes),
    .in_request_alignment (in_request_alignment),
    .in_item_tag          (in_item_tag),
    .in_new_plan          (in_new_plan),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_tag_out          (out_tag_out),
    .out_buffer_number    (out_buffer_number),
    .out_device_offset    (out_device_offset),
    .out_request_offset   (out_request_offset),
    .out_slice_bytes      (out_slice_bytes),
    .out_fill_after       (out_fill_after),
    .out_last_slice       (out_last_slice),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // ---------------------------------------------------------------- predictor

  function automatic bit single_bit(logic [63:0] x);
    return (x != 0) && ((x & (x - 1)) == 0);
  endfunction

  function automatic slice_t make_slice(logic [asp_pkg::STAT_W-1:0] st,
                                        logic [asp_pkg::TAG_W-1:0] tag,
                                        logic [asp_pkg::BUF_W-1:0] bufn,
                                        logic [asp_pkg::BYTES_W-1:0] doff,
                                        logic [asp_pkg::BYTES_W-1:0] loff,
                                        logic [asp_pkg::BYTES_W-1:0] len,
                                        logic [asp_pkg::CAP_W-1:0] fill, logic last);
    slice_t s;
    s.status  = st;
    s.tag     = tag;
    s.buf_num = bufn;
    s.dev_off = doff;
    s.log_off = loff;
    s.len     = len;
    s.fill    = fill;
    s.last    = last;
    return s;
  endfunction

  // places one request into the plan, leaving its slices in new_slices
  function automatic void place_request(req_t r);
    logic [63:0]                eff;
    logic [63:0]                aligned;
    logic [63:0]                room;
    logic [63:0]                len;
    logic [63:0]                remaining;
    logic [63:0]                logical;
    logic [asp_pkg::STAT_W-1:0] code;
    int                         n;
    new_slices.delete();
    if (r.np) begin
      plan_buffer = 0;
      plan_fill   = 0;
      plan_failed = 1'b0;
    end
    // error checks in priority order
    code = asp_pkg::ST_OK;
    if (plan_failed) code = asp_pkg::ST_FAILED_EARLIER;
    else if (!single_bit(plan_base_align)) code = asp_pkg::ST_BAD_BASE_ALIGN;
    else if (r.nbytes == 0) code = asp_pkg::ST_ZERO_SIZE;
    else if (!single_bit(64'(r.ralign))) code = asp_pkg::ST_BAD_ITEM_ALIGN;
    if (code != asp_pkg::ST_OK) begin
      plan_failed = 1'b1;
      new_slices.insert(new_slices.size(),
                        make_slice(code, r.tag, plan_buffer[asp_pkg::BUF_W-1:0],
                                   0, 0, 0, 0, 1'b1));
      return;
    end
    eff       = (plan_base_align > 64'(r.ralign)) ? plan_base_align : 64'(r.ralign);
    remaining = 64'(r.nbytes);
    logical   = 0;
    n         = 0;
    while (remaining != 0 && n < 33) begin
      aligned = (plan_fill + eff - 1) & ~(eff - 1);
      if (aligned >= plan_capacity) begin
        // no room left: next buffer, or overflow with earlier slices kept
        if (plan_buffer + 1 >= BUF_LIMIT) begin
          plan_failed = 1'b1;
          new_slices.insert(new_slices.size(),
                            make_slice(asp_pkg::ST_INDEX_OVERFLOW, r.tag,
                                       plan_buffer[asp_pkg::BUF_W-1:0],
                                       0, 0, 0, 0, 1'b1));
          return;
        end
        plan_buffer++;
        plan_fill = 0;
      end else begin
        room      = plan_capacity - aligned;
        len       = (room < remaining) ? room : remaining;
        plan_fill = aligned + len;
        remaining = remaining - len;
        new_slices.insert(new_slices.size(),
                          make_slice(asp_pkg::ST_OK, r.tag, plan_buffer[asp_pkg::BUF_W-1:0],
                                     aligned[asp_pkg::BYTES_W-1:0],
                                     logical[asp_pkg::BYTES_W-1:0],
                                     len[asp_pkg::BYTES_W-1:0],
                                     plan_fill[asp_pkg::CAP_W-1:0],
                                     remaining == 0));
        logical = logical + len;
        n++;
      end
    end
  endfunction

  // ----------------------------------------------------------- table helpers

  function automatic row_t req_row(logic [asp_pkg::BYTES_W-1:0] nbytes,
                                   logic [asp_pkg::ALIGN_W-1:0] ralign,
                                   logic [asp_pkg::TAG_W-1:0] tag, logic np);
    row_t w;
    w.kind       = ROW_REQUEST;
    w.req.nbytes = nbytes;
    w.req.ralign = ralign;
    w.req.tag    = tag;
    w.req.np     = np;
    w.reg_idx    = '0;
    w.reg_data   = '0;
    w.typed      = 1'b0;
    w.want       = make_slice(asp_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 1'b0);
    return w;
  endfunction

  // single-slice request whose result is written out by hand
  function automatic row_t typed_row(logic [asp_pkg::BYTES_W-1:0] nbytes,
                                     logic [asp_pkg::ALIGN_W-1:0] ralign,
                                     logic [asp_pkg::TAG_W-1:0] tag, logic np,
                                     logic [asp_pkg::STAT_W-1:0] st,
                                     logic [asp_pkg::BUF_W-1:0] bufn,
                                     logic [asp_pkg::BYTES_W-1:0] doff,
                                     logic [asp_pkg::BYTES_W-1:0] len,
                                     logic [asp_pkg::CAP_W-1:0] fill);
    row_t w;
    w       = req_row(nbytes, ralign, tag, np);
    w.typed = 1'b1;
    w.want  = make_slice(st, tag, bufn, doff, 0, len, fill, 1'b1);
    return w;
  endfunction

  function automatic row_t reg_row(logic [asp_pkg::CFG_IDX_W-1:0] idx,
                                   logic [asp_pkg::CFG_DATA_W-1:0] data);
    row_t w;
    w          = req_row(0, 0, 0, 1'b0);
    w.kind     = ROW_CONFIG;
    w.reg_idx  = idx;
    w.reg_data = data;
    return w;
  endfunction

  // mostly well-formed requests; a failed plan is usually restarted
  function automatic req_t random_request();
    req_t        r;
    int unsigned sel;
    int          k;
    r.tag = 16'($urandom);
    if (plan_failed) r.np = ($urandom_range(0, 9) < 7);
    else r.np = ($urandom_range(0, 19) == 0);
    sel = $urandom_range(0, 99);
    if (sel < 3) r.nbytes = 0;
    else if (sel < 50) r.nbytes = $urandom_range(1, 4096);
    else if (sel < 80) r.nbytes = $urandom_range(1, 32'h0100_0000);
    else if (sel < 93) r.nbytes = $urandom_range(1, 32'h1000_0000);
    else r.nbytes = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 3) begin
      r.ralign = 0;
    end else if (sel < 6) begin
      r.ralign = $urandom;
    end else begin
      k = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 12);
      r.ralign = 32'd1 << k;
    end
    return r;
  endfunction

  // ------------------------------------------------------------- bus drivers

  // one request transaction; the slices it causes join the awaited queue
  task automatic put_request(req_t r, bit typed, slice_t want);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_request_bytes     <= r.nbytes;
    in_request_alignment <= r.ralign;
    in_item_tag          <= r.tag;
    in_new_plan          <= r.np;
    do @(posedge clk); while (in_stall);
    place_request(r);
    if (typed) awaited_slices.insert(awaited_slices.size(), want);
    else foreach (new_slices[i]) awaited_slices.insert(awaited_slices.size(), new_slices[i]);
  endtask

  // register write; only called with the block drained
  task automatic write_register(logic [asp_pkg::CFG_IDX_W-1:0] idx,
                                logic [asp_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == asp_pkg::REG_BUFFER_CAPACITY) begin
      // capacity is clamped into its legal window
      if (data < asp_pkg::CAP_MIN) plan_capacity = 64'(asp_pkg::CAP_MIN);
      else if (data > asp_pkg::CAP_MAX) plan_capacity = 64'(asp_pkg::CAP_MAX);
      else plan_capacity = 64'(data);
    end else begin
      plan_base_align = 64'(data[asp_pkg::ALIGN_W-1:0]);
    end
  endtask

  // hold requests until every awaited slice is in, then let the block settle
  task automatic drain_results();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (awaited_slices.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_slices.size() != 0) begin
      $error("%0d awaited slices never arrived", awaited_slices.size());
      fail_count++;
      awaited_slices.delete();
    end
  endtask

  // result side back-pressure: after each slice transaction a random stall, if enabled
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end else if (out_valid && !out_stall) begin
      stall_draw = idle_on ? $urandom_range(0, 5) : 0;
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end
  end

  // --------------------------------------------------------------- checking

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // every slice transaction is matched against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_slices.size() == 0) begin
        $error("slice with no request behind it, tag %0h", out_tag_out);
        fail_count++;
      end else begin
        head = awaited_slices.pop_front();
        check_field("status", 64'(head.status), 64'(out_status));
        check_field("tag_out", 64'(head.tag), 64'(out_tag_out));
        check_field("buffer_number", 64'(head.buf_num), 64'(out_buffer_number));
        check_field("device_offset", 64'(head.dev_off), 64'(out_device_offset));
        check_field("request_offset", 64'(head.log_off), 64'(out_request_offset));
        check_field("slice_bytes", 64'(head.len), 64'(out_slice_bytes));
        check_field("fill_after", 64'(head.fill), 64'(out_fill_after));
        check_field("last_slice", 64'(head.last), 64'(out_last_slice));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    slice_t      blank;
    req_t        r;
    bit          restart;
    int          n_items;
    int          k;
    logic [32:0] cap_data;
    logic [32:0] base_data;

    blank           = make_slice(asp_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 1'b0);
    plan_capacity   = 64'(asp_pkg::CAP_RESET);
    plan_base_align = 64'(asp_pkg::BASE_ALIGN_RESET);
    plan_fill       = 0;
    plan_buffer     = 0;
    plan_failed     = 1'b0;

    // directed table, starting from reset values: 256 MiB buffers, 256 B base
    // smallest request, then base alignment rounding of the fill
    script.insert(script.size(), typed_row(1, 1, 16'h0000, 1, asp_pkg::ST_OK, 0, 0, 1, 1));
    script.insert(script.size(), typed_row(1, 1, 16'hFFFF, 0, asp_pkg::ST_OK, 0, 256, 1, 257));
    // zero size, then the sticky failure
    script.insert(script.size(), typed_row(0, 1, 16'h1234, 0, asp_pkg::ST_ZERO_SIZE,
                                           0, 0, 0, 0));
    script.insert(script.size(), typed_row(5, 1, 16'h0F0F, 0, asp_pkg::ST_FAILED_EARLIER,
                                           0, 0, 0, 0));
    // bad item alignments; zero size wins over a bad alignment
    script.insert(script.size(), typed_row(16, 3, 16'hAAAA, 1, asp_pkg::ST_BAD_ITEM_ALIGN,
                                           0, 0, 0, 0));
    script.insert(script.size(), typed_row(0, 0, 16'h5555, 1, asp_pkg::ST_ZERO_SIZE,
                                           0, 0, 0, 0));
    script.insert(script.size(), typed_row(32'hAAAA_AAAA, 32'h5555_5555, 16'hF0F0, 1,
                                           asp_pkg::ST_BAD_ITEM_ALIGN, 0, 0, 0, 0));
    script.insert(script.size(), typed_row(16, 0, 16'h0001, 1, asp_pkg::ST_BAD_ITEM_ALIGN,
                                           0, 0, 0, 0));
    // largest request at the largest alignment, split over 16 buffers
    script.insert(script.size(), req_row(32'hFFFF_FFFF, 32'h8000_0000, 16'h8000, 1));
    // request ending exactly at capacity, next one opens a fresh buffer
    script.insert(script.size(), typed_row(32'h1000_0000, 1, 16'h7FFF, 1, asp_pkg::ST_OK,
                                           0, 0, 32'h1000_0000, 33'h0_1000_0000));
    script.insert(script.size(), typed_row(1, 1, 16'h0100, 0, asp_pkg::ST_OK, 1, 0, 1, 1));
    script.insert(script.size(), req_row(32'h0FFF_FFFF, 32'h100, 16'h0200, 0));
    script.insert(script.size(), typed_row(32'h0C00_0000, 1, 16'h0300, 0, asp_pkg::ST_OK,
                                           2, 256, 32'h0C00_0000, 33'h0_0C00_0100));
    // capacity lowered below the fill mid-plan: clamp to minimum, then move on
    script.insert(script.size(), reg_row(asp_pkg::REG_BUFFER_CAPACITY, 33'd0));
    script.insert(script.size(), typed_row(1, 1, 16'h0400, 0, asp_pkg::ST_OK, 3, 0, 1, 1));
    // capacity above the maximum clamps to 4 GiB
    script.insert(script.size(), reg_row(asp_pkg::REG_BUFFER_CAPACITY, 33'h1_FFFF_FFFF));
    script.insert(script.size(), typed_row(32'hFFFF_FFFF, 32'h8000_0000, 16'h0500, 1,
                                           asp_pkg::ST_OK, 0, 0,
                                           32'hFFFF_FFFF, 33'h0_FFFF_FFFF));
    script.insert(script.size(), typed_row(1, 1, 16'h0600, 0, asp_pkg::ST_OK, 1, 0, 1, 1));
    script.insert(script.size(), reg_row(asp_pkg::REG_BUFFER_CAPACITY, 33'h1_0000_0000));
    // bad base alignment outranks zero size, then sticks
    script.insert(script.size(), reg_row(asp_pkg::REG_BASE_ALIGNMENT, 33'd0));
    script.insert(script.size(), typed_row(0, 0, 16'h0700, 1, asp_pkg::ST_BAD_BASE_ALIGN,
                                           0, 0, 0, 0));
    script.insert(script.size(), typed_row(1, 1, 16'h0800, 0, asp_pkg::ST_FAILED_EARLIER,
                                           0, 0, 0, 0));
    script.insert(script.size(), reg_row(asp_pkg::REG_BASE_ALIGNMENT, 33'h0_FFFF_FFFF));
    script.insert(script.size(), typed_row(8, 8, 16'h0900, 1, asp_pkg::ST_BAD_BASE_ALIGN,
                                           0, 0, 0, 0));
    // largest base alignment; bit 32 of the write data is dropped
    script.insert(script.size(), reg_row(asp_pkg::REG_BASE_ALIGNMENT, 33'h1_8000_0000));
    script.insert(script.size(), typed_row(32'h1234_5678, 1, 16'h0A00, 1, asp_pkg::ST_OK,
                                           0, 0, 32'h1234_5678, 33'h0_1234_5678));
    script.insert(script.size(), typed_row(16, 1, 16'h0B00, 0, asp_pkg::ST_OK, 0,
                                           32'h8000_0000, 16, 33'h0_8000_0010));
    // byte alignment and a capacity just under the minimum
    script.insert(script.size(), reg_row(asp_pkg::REG_BASE_ALIGNMENT, 33'd1));
    script.insert(script.size(), reg_row(asp_pkg::REG_BUFFER_CAPACITY, 33'h0_07FF_FFFF));
    script.insert(script.size(), typed_row(3, 2, 16'h0C00, 1, asp_pkg::ST_OK, 0, 0, 3, 3));
    script.insert(script.size(), typed_row(5, 2, 16'h0D00, 0, asp_pkg::ST_OK, 0, 4, 5, 9));
    script.insert(script.size(), req_row(32'h7FFF_FFFF, 32'h10, 16'h0E00, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CONFIG) begin
        drain_results();
        write_register(script[i].reg_idx, script[i].reg_data);
      end else begin
        put_request(script[i].req, script[i].typed, script[i].want);
      end
    end

    // run the plan into index overflow: largest requests into minimum buffers,
    // no gaps or stalls so that it stays short
    drain_results();
    write_register(asp_pkg::REG_BUFFER_CAPACITY, 33'd0);
    drain_results();
    write_register(asp_pkg::REG_BASE_ALIGNMENT, 33'd1);
    idle_on = 1'b0;
    restart = 1'b1;
    do begin
      r.nbytes = 32'hFFFF_FFFF;
      r.ralign = 32'd1;
      r.tag    = 16'($urandom);
      r.np     = restart;
      restart  = 1'b0;
      put_request(r, 1'b0, blank);
    end while (!plan_failed);
    r.np = 1'b0;
    put_request(r, 1'b0, blank);
    idle_on = 1'b1;

    // random phases, each under its own capacity and base alignment
    for (int p = 0; p < 6; p++) begin
      drain_results();
      if (p == 0) cap_data = 33'd0;
      else if (p == 1) cap_data = 33'h1_FFFF_FFFF;
      else cap_data = {1'($urandom_range(0, 1)), $urandom};
      write_register(asp_pkg::REG_BUFFER_CAPACITY, cap_data);
      drain_results();
      if (p == 3) begin
        // short phase where every request fails, on the base alignment or as failed earlier
        base_data = {1'($urandom_range(0, 1)), ($urandom | 32'h3)};
      end else if (p == 4) begin
        base_data = {1'($urandom_range(0, 1)), 32'h8000_0000};
      end else begin
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 12);
        base_data = {1'($urandom_range(0, 1)), 32'd1 << k};
      end
      write_register(asp_pkg::REG_BASE_ALIGNMENT, base_data);
      n_items = (p == 3) ? 20 : 90;
      for (int i = 0; i < n_items; i++) begin
        // stretches with and without random gaps and stalls
        if (i % 25 == 0) idle_on = ($urandom_range(0, 3) != 0);
        // now and then the sender holds off until the block is empty
        if ($urandom_range(0, 49) == 0) drain_results();
        put_request(random_request(), 1'b0, blank);
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #60_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
